FILE: sv/u16550_pkg.sv
// Shared types and constants for the 16550-style UART register file.
// No dependencies; used by u16550_regs and uart_16550_register_file_unit.
package u16550_pkg;

   // Transaction kinds on the request channel
   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_LINE  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // Register offsets from the port base
   typedef enum logic [2:0] {
      REG_DATA    = 3'd0,   // RBR / THR, or DLL with DLAB
      REG_IER     = 3'd1,   // IER, or DLM with DLAB
      REG_IIR     = 3'd2,   // IIR on read, FCR on write
      REG_LCR     = 3'd3,
      REG_MCR     = 3'd4,
      REG_LSR     = 3'd5,
      REG_MSR     = 3'd6,
      REG_SCRATCH = 3'd7
   } reg_offset_type;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned DIVISOR_W  = 16;
   localparam int unsigned IER_W      = 4;
   localparam int unsigned MCR_W      = 5;

   // Bit positions
   localparam int unsigned LCR_DLAB_BIT = 7;
   localparam int unsigned MCR_DTR_BIT  = 0;
   localparam int unsigned MCR_RTS_BIT  = 1;
   localparam int unsigned MCR_OUT1_BIT = 2;
   localparam int unsigned MCR_OUT2_BIT = 3;
   localparam int unsigned MCR_LOOP_BIT = 4;
   localparam int unsigned IER_RDA_BIT  = 0;

   // IIR codes
   localparam logic [BYTE_W-1:0] IIR_RX_PENDING = 8'h04;
   localparam logic [BYTE_W-1:0] IIR_NO_PENDING = 8'h01;

   // One request transaction
   typedef struct packed {
      kind_type            kind;
      reg_offset_type      reg_offset;
      logic [BYTE_W-1:0]   write_data;
      logic [BYTE_W-1:0]   line_byte;
   } req_item_type;

   // One response transaction
   typedef struct packed {
      logic [BYTE_W-1:0]   read_data;
      logic                tx_valid;
      logic [BYTE_W-1:0]   tx_byte;
      logic                irq_out;
   } rsp_item_type;

endpackage

FILE: sv/u16550_regs.sv
// UART register state and access decode: one transaction per enabled cycle.
// Depends on u16550_pkg for the transaction types and register map.
module u16550_regs (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  u16550_pkg::req_item_type item,
   output u16550_pkg::rsp_item_type result
);

   logic [u16550_pkg::DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [u16550_pkg::BYTE_W-1:0]    lcr_ff, lcr_in;
   logic [u16550_pkg::IER_W-1:0]     ier_ff, ier_in;
   logic [u16550_pkg::MCR_W-1:0]     mcr_ff, mcr_in;
   logic [u16550_pkg::BYTE_W-1:0]    rx_ff, rx_in;
   logic                             data_ready_ff, data_ready_in;
   logic                             overrun_ff, overrun_in;
   logic [u16550_pkg::BYTE_W-1:0]    scratch_ff, scratch_in;

   logic                             dlab;
   logic                             loop_mode;
   logic                             irq_now;
   logic                             rx_take;
   logic [u16550_pkg::BYTE_W-1:0]    rx_byte;

   assign dlab      = lcr_ff[u16550_pkg::LCR_DLAB_BIT];
   assign loop_mode = mcr_ff[u16550_pkg::MCR_LOOP_BIT];
   assign irq_now   = mcr_ff[u16550_pkg::MCR_OUT2_BIT] & ier_ff[u16550_pkg::IER_RDA_BIT]
                      & data_ready_ff;

   // Access decode and next state
   always_comb begin
      divisor_in    = divisor_ff;
      lcr_in        = lcr_ff;
      ier_in        = ier_ff;
      mcr_in        = mcr_ff;
      scratch_in    = scratch_ff;
      overrun_in    = overrun_ff;
      rx_take       = 1'b0;
      rx_byte       = item.line_byte;
      result        = '0;
      // read side effects applied to data_ready before a receive can set it
      data_ready_in = data_ready_ff;

      unique case (item.kind)
         u16550_pkg::KIND_READ: begin
            unique case (item.reg_offset)
               u16550_pkg::REG_DATA: begin
                  if (dlab) begin
                     result.read_data = divisor_ff[u16550_pkg::BYTE_W-1:0];
                  end else begin
                     result.read_data = rx_ff;
                     data_ready_in    = 1'b0;
                  end
               end
               u16550_pkg::REG_IER: begin
                  result.read_data = dlab ? divisor_ff[u16550_pkg::DIVISOR_W-1:u16550_pkg::BYTE_W]
                                          : {4'b0000, ier_ff};
               end
               u16550_pkg::REG_IIR: begin
                  result.read_data = irq_now ? u16550_pkg::IIR_RX_PENDING
                                             : u16550_pkg::IIR_NO_PENDING;
               end
               u16550_pkg::REG_LCR:     result.read_data = lcr_ff;
               u16550_pkg::REG_MCR:     result.read_data = {3'b000, mcr_ff};
               u16550_pkg::REG_LSR: begin
                  result.read_data = {2'b00, 1'b1, 3'b000, overrun_ff, data_ready_ff};
                  overrun_in       = 1'b0;
               end
               u16550_pkg::REG_MSR: begin
                  if (loop_mode) begin
                     result.read_data = {mcr_ff[u16550_pkg::MCR_OUT2_BIT],
                                         mcr_ff[u16550_pkg::MCR_OUT1_BIT],
                                         mcr_ff[u16550_pkg::MCR_DTR_BIT],
                                         mcr_ff[u16550_pkg::MCR_RTS_BIT],
                                         4'b0000};
                  end
               end
               u16550_pkg::REG_SCRATCH: result.read_data = scratch_ff;
               default:                 result.read_data = '0;
            endcase
         end
         u16550_pkg::KIND_WRITE: begin
            unique case (item.reg_offset)
               u16550_pkg::REG_DATA: begin
                  if (dlab) begin
                     divisor_in[u16550_pkg::BYTE_W-1:0] = item.write_data;
                  end else if (loop_mode) begin
                     rx_take = 1'b1;
                     rx_byte = item.write_data;
                  end else begin
                     result.tx_valid = 1'b1;
                     result.tx_byte  = item.write_data;
                  end
               end
               u16550_pkg::REG_IER: begin
                  if (dlab) begin
                     divisor_in[u16550_pkg::DIVISOR_W-1:u16550_pkg::BYTE_W] = item.write_data;
                  end else begin
                     ier_in = item.write_data[u16550_pkg::IER_W-1:0];
                  end
               end
               u16550_pkg::REG_LCR:     lcr_in     = item.write_data;
               u16550_pkg::REG_MCR:     mcr_in     = item.write_data[u16550_pkg::MCR_W-1:0];
               u16550_pkg::REG_SCRATCH: scratch_in = item.write_data;
               // FCR, LSR and MSR writes have no effect
               default: ;
            endcase
         end
         u16550_pkg::KIND_LINE: begin
            // serial input is cut off in loopback
            rx_take = !loop_mode;
         end
         default: ;
      endcase

      // Receive path: a byte landing on unread data flags overrun
      if (rx_take) begin
         if (data_ready_ff) begin
            overrun_in = 1'b1;
         end
         data_ready_in = 1'b1;
      end
      rx_in = rx_take ? rx_byte : rx_ff;

      result.irq_out = mcr_in[u16550_pkg::MCR_OUT2_BIT] & ier_in[u16550_pkg::IER_RDA_BIT]
                       & data_ready_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff    <= '0;
         lcr_ff        <= '0;
         ier_ff        <= '0;
         mcr_ff        <= '0;
         rx_ff         <= '0;
         data_ready_ff <= 1'b0;
         overrun_ff    <= 1'b0;
         scratch_ff    <= '0;
      end else if (step_en) begin
         divisor_ff    <= divisor_in;
         lcr_ff        <= lcr_in;
         ier_ff        <= ier_in;
         mcr_ff        <= mcr_in;
         rx_ff         <= rx_in;
         data_ready_ff <= data_ready_in;
         overrun_ff    <= overrun_in;
         scratch_ff    <= scratch_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A raised interrupt always leaves data ready behind
   a_irq_has_data: assert property (@(posedge clock) disable iff (reset)
      step_en && result.irq_out |=> data_ready_ff)
      else $error("irq raised without data ready");

   // Nothing goes out on the line in loopback or with DLAB set
   a_tx_gated: assert property (@(posedge clock) disable iff (reset)
      step_en && result.tx_valid |-> !loop_mode && !dlab)
      else $error("tx byte emitted in loopback or DLAB mode");

   // Read data is zero unless the transaction is a bus read
   a_rdata_only_on_read: assert property (@(posedge clock) disable iff (reset)
      step_en && item.kind != u16550_pkg::KIND_READ |-> result.read_data == '0)
      else $error("read data nonzero on non-read transaction");

   // A line byte outside loopback lands in the holding register
   a_line_capture: assert property (@(posedge clock) disable iff (reset)
      step_en && item.kind == u16550_pkg::KIND_LINE && !loop_mode
      |=> data_ready_ff && rx_ff == $past(item.line_byte))
      else $error("line byte not captured");
`endif

endmodule

FILE: sv/uart_16550_register_file_unit.sv
// Top level of the 16550-style UART register file: request/response pipeline.
// Depends on u16550_pkg and u16550_regs.
//
// Usage:
//   Request channel (req_*): one transaction is a bus read (kind 0), a bus write
//   (kind 1) at offsets 0..7, or a byte arriving from the serial line (kind 2).
//   Kind 3 changes nothing and only reports the interrupt level.
//   Response channel (rsp_*): exactly one response per request, in order, with
//   the read data, an outgoing line byte with its valid flag, and the
//   interrupt level after the transaction.
//   A transaction moves at a clock edge where valid is high and stall is low.
//   Response path: a request passes through the input register, then the
//   response register, where rsp_valid rises; a receiver stall can hold it
//   in the input register. Throughput: one transaction per cycle while rsp_stall
//   is low; register state is updated as a request moves into the response register.
//   Receiver stall: the response register holds; the held request waits in
//   the input register and req_stall rises once both are full.
//   Reset: register file state clears to zero, both pipeline stages empty; payloads are not reset.
module uart_16550_register_file_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [2:0] req_reg_offset,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_line_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_irq_out
);

   logic                     in_valid_ff, in_valid_in;
   u16550_pkg::req_item_type in_item_ff, in_item_in;
   logic                     out_valid_ff, out_valid_in;
   u16550_pkg::rsp_item_type out_item_ff, out_item_in;
   u16550_pkg::rsp_item_type step_result;
   logic                     advance;
   logic                     req_take;

   // Pipeline handshake
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_item_in.kind       = u16550_pkg::kind_type'(req_kind);
      in_item_in.reg_offset = u16550_pkg::reg_offset_type'(req_reg_offset);
      in_item_in.write_data = req_write_data;
      in_item_in.line_byte  = req_line_byte;

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      out_item_in = advance ? step_result : out_item_ff;
   end

   // Register file and access decode
   u16550_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (step_result)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item_in;
      end
      out_item_ff <= out_item_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_item_ff.read_data;
   assign rsp_tx_valid  = out_item_ff.tx_valid;
   assign rsp_tx_byte   = out_item_ff.tx_byte;
   assign rsp_irq_out   = out_item_ff.irq_out;

endmodule
